### rtl/core/qepv_pkg.sv
// ----------------------------------------------------------------------------
// qepv_pkg
// shared types and constants for the quadrature encoder position/velocity core
// ----------------------------------------------------------------------------
package qepv_pkg;

    // item kinds
    localparam logic [1:0] MODE_PIN   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // configuration register indexes
    localparam logic CFG_COUNTS_PER_REV = 1'b0;
    localparam logic CFG_WINDOW_MS      = 1'b1;

    // register reset values
    localparam logic [15:0] CPR_RESET = 16'd1560;
    localparam logic [9:0]  WIN_RESET = 10'd200;

    // arithmetic constants
    localparam logic [19:0] DEG_PER_REV = 20'd360;
    localparam int          MS_PER_S    = 1000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POS_SETUP,
        ST_K_DIV,
        ST_SPD_MUL,
        ST_SPD_DIV,
        ST_POS_MUL,
        ST_POS_DIV,
        ST_OUT
    } qepv_state_t;

endpackage

### rtl/core/qepv_in_if.sv
// ----------------------------------------------------------------------------
// qepv_in_if
// input channel: one encoder transaction (pin sample, clear or tick)
// ----------------------------------------------------------------------------
interface qepv_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic       chan_a;
    logic       chan_b;

    modport source (output valid, output mode, output chan_a, output chan_b, input ready);
    modport sink   (input valid, input mode, input chan_a, input chan_b, output ready);
endinterface

### rtl/core/qepv_out_if.sv
// ----------------------------------------------------------------------------
// qepv_out_if
// result channel: position, velocity and counter state after one transaction
// ----------------------------------------------------------------------------
interface qepv_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position_deg;
    logic        [31:0] velocity_rpm_q4;
    logic        [15:0] raw_count;
    logic signed [15:0] wrap_count;
    logic               window_done;

    modport source (output valid, output position_deg, output velocity_rpm_q4,
                    output raw_count, output wrap_count, output window_done,
                    input ready);
    modport sink   (input valid, input position_deg, input velocity_rpm_q4,
                    input raw_count, input wrap_count, input window_done,
                    output ready);
endinterface

### rtl/core/quadrature_encoder_position_velocity_core.sv
// ----------------------------------------------------------------------------
// quadrature_encoder_position_velocity_core
// x4 quadrature decoder with wrap count, degree position and windowed rpm
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. The core holds ready low while
// it works on a transaction; a finished result sits in the output register so
// the next transaction can be taken while it waits. Multiply and divide run
// on one shared adder: shift-add multiply (one multiplier bit a cycle,
// stopping when the remaining bits are zero) and restoring divide (one
// quotient bit a cycle, NW = max(COUNTER_BITS+24, 51) steps, 51 at the
// default). Every transaction runs the position steps: setup, multiply of
// the count magnitude by 360, divide by counts_per_rev, then output. A tick
// that closes a velocity window first runs 1000/window_ms through the
// divider, multiplies the count delta by 960*(1000/window_ms) and divides by
// counts_per_rev. Config writes are taken at any time but are meant for idle
// periods only.
// ----------------------------------------------------------------------------
module quadrature_encoder_position_velocity_core
    import qepv_pkg::*;
#(
    parameter int COUNTER_BITS = 16
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_data,
    qepv_in_if.sink     item,
    qepv_out_if.source  result
);

    // widths
    localparam int CB    = COUNTER_BITS;
    localparam int EW    = CB + 16;                      // extended count
    localparam int XW    = (EW > 32) ? EW : 32;          // sign-extended for mod 2^32
    localparam int NW    = (CB + 24 > 51) ? CB + 24 : 51; // shared datapath
    localparam int CNT_W = $clog2(NW + 1);
    localparam logic [NW-1:0] MS_NUM = NW'(MS_PER_S);

    // configuration registers
    logic [15:0] cpr_reg, cpr_next;
    logic [9:0]  win_reg, win_next;

    // encoder state
    logic [1:0]    pins_reg, pins_next;
    logic [CB-1:0] low_reg, low_next;
    logic [15:0]   wraps_reg, wraps_next;
    logic [31:0]   wstart_reg, wstart_next;
    logic [9:0]    tick_reg, tick_next;
    logic [31:0]   speed_reg, speed_next;
    logic          done_reg, done_next;

    // sequencer and shared unit
    qepv_state_t      state_reg, state_next;
    logic [NW-1:0]    a_reg, a_next;      // accumulator / dividend-quotient
    logic [NW-1:0]    b_reg, b_next;      // multiplicand
    logic [15:0]      r_reg, r_next;      // partial remainder
    logic [19:0]      m_reg, m_next;      // multiplier
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // output register
    logic        ov_reg, ov_next;
    logic [31:0] opos_reg, opos_next;
    logic [31:0] ospd_reg, ospd_next;
    logic [15:0] oraw_reg, oraw_next;
    logic [15:0] owrap_reg, owrap_next;
    logic        odone_reg, odone_next;

    // derived values
    logic [15:0]         cpr_eff;
    logic [9:0]          win_eff;
    logic signed [EW-1:0] ext_s;
    logic signed [XW-1:0] ext_x;
    logic [EW-1:0]       ext_mag;
    logic [31:0]         now_cnt;
    logic [31:0]         diff;
    logic [31:0]         diff_mag;
    logic [10:0]         tick_plus;
    logic                step_up;
    logic                step_dn;
    logic [1:0]          pins_in;
    logic [9:0]          k_ratio;

    // shared adder
    logic          is_div;
    logic [16:0]   div_t;
    logic [15:0]   div_den;
    logic [NW:0]   opa;
    logic [NW:0]   opb;
    logic [NW:0]   sum;
    logic          qbit;

    // position saturation
    logic [31:0] pos_sat;

    assign cpr_eff = (cpr_reg == 16'd0) ? 16'd1 : cpr_reg;
    assign win_eff = (win_reg == 10'd0) ? 10'd1 : win_reg;

    // extended count is just wraps on top of the low counter
    assign ext_s    = signed'({wraps_reg, low_reg});
    assign ext_x    = XW'(ext_s);
    assign ext_mag  = ext_s[EW-1] ? EW'(-ext_s) : EW'(ext_s);
    assign now_cnt  = ext_x[31:0];
    assign diff     = now_cnt - wstart_reg;
    assign diff_mag = diff[31] ? (32'd0 - diff) : diff;
    assign tick_plus = {1'b0, tick_reg} + 11'd1;
    assign k_ratio  = a_reg[9:0];

    // gray step decode: 0->2->3->1->0 counts up, the reverse counts down
    assign pins_in = {item.chan_a, item.chan_b};
    always_comb
    begin
        step_up = 1'b0;
        step_dn = 1'b0;
        unique case ({pins_reg, pins_in})
            4'b00_10, 4'b10_11, 4'b11_01, 4'b01_00: step_up = 1'b1;
            4'b00_01, 4'b01_11, 4'b11_10, 4'b10_00: step_dn = 1'b1;
            default: ;
        endcase
    end

    // shared unit: add for multiply, subtract-and-test for divide
    assign is_div  = (state_reg == ST_K_DIV) || (state_reg == ST_SPD_DIV) ||
                     (state_reg == ST_POS_DIV);
    assign div_t   = {r_reg, a_reg[NW-1]};
    assign div_den = (state_reg == ST_K_DIV) ? 16'(win_eff) : cpr_eff;
    assign opa     = is_div ? (NW+1)'(div_t) : {1'b0, a_reg};
    assign opb     = is_div ? ~((NW+1)'(div_den)) : {1'b0, b_reg};
    assign sum     = opa + opb + (NW+1)'(is_div);
    assign qbit    = ~sum[NW];

    // final quotient in a_reg is the degree magnitude
    always_comb
    begin
        if (ext_s[EW-1])
        begin
            if (a_reg[NW-1:31] != '0)
                pos_sat = 32'h8000_0000;
            else
                pos_sat = 32'd0 - a_reg[31:0];
        end
        else
        begin
            if (a_reg[NW-1:31] != '0)
                pos_sat = 32'h7FFF_FFFF;
            else
                pos_sat = a_reg[31:0];
        end
    end

    assign item.ready             = (state_reg == ST_IDLE);
    assign result.valid           = ov_reg;
    assign result.position_deg    = signed'(opos_reg);
    assign result.velocity_rpm_q4 = ospd_reg;
    assign result.raw_count       = oraw_reg;
    assign result.wrap_count      = signed'(owrap_reg);
    assign result.window_done     = odone_reg;

    always_comb
    begin
        cpr_next    = cpr_reg;
        win_next    = win_reg;
        pins_next   = pins_reg;
        low_next    = low_reg;
        wraps_next  = wraps_reg;
        wstart_next = wstart_reg;
        tick_next   = tick_reg;
        speed_next  = speed_reg;
        done_next   = done_reg;
        state_next  = state_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        r_next      = r_reg;
        m_next      = m_reg;
        cnt_next    = cnt_reg;
        ov_next     = ov_reg;
        opos_next   = opos_reg;
        ospd_next   = ospd_reg;
        oraw_next   = oraw_reg;
        owrap_next  = owrap_reg;
        odone_next  = odone_reg;

        // config write port
        if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_COUNTS_PER_REV: cpr_next = cfg_data;
                CFG_WINDOW_MS:      win_next = cfg_data[9:0];
                default: ;
            endcase
        end

        if (result.valid && result.ready)
            ov_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    done_next  = 1'b0;
                    state_next = ST_POS_SETUP;
                    unique case (item.mode)
                        MODE_PIN:
                        begin
                            pins_next = pins_in;
                            if (step_up)
                            begin
                                low_next = low_reg + CB'(1);
                                if (low_reg == '1)
                                    wraps_next = wraps_reg + 16'd1;
                            end
                            else if (step_dn)
                            begin
                                low_next = low_reg - CB'(1);
                                if (low_reg == '0)
                                    wraps_next = wraps_reg - 16'd1;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            low_next = '0;
                        end
                        MODE_TICK:
                        begin
                            if (tick_plus < {1'b0, win_eff})
                            begin
                                tick_next = tick_plus[9:0];
                            end
                            else
                            begin
                                // window closes: delta magnitude waits in b,
                                // divider starts on 1000/window
                                tick_next   = '0;
                                done_next   = 1'b1;
                                wstart_next = now_cnt;
                                b_next      = NW'(diff_mag);
                                a_next      = MS_NUM;
                                r_next      = '0;
                                cnt_next    = CNT_W'(NW);
                                state_next  = ST_K_DIV;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_K_DIV:
            begin
                if (cnt_reg != '0)
                begin
                    a_next   = {a_reg[NW-2:0], qbit};
                    r_next   = qbit ? sum[15:0] : div_t[15:0];
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    // scale = 960 * k = (k << 10) - (k << 6), i.e. 60 s/min * 16
                    m_next     = {k_ratio, 10'd0} - {4'd0, k_ratio, 6'd0};
                    a_next     = '0;
                    state_next = ST_SPD_MUL;
                end
            end

            ST_SPD_MUL, ST_POS_MUL:
            begin
                if (m_reg != '0)
                begin
                    if (m_reg[0])
                        a_next = sum[NW-1:0];
                    b_next = {b_reg[NW-2:0], 1'b0};
                    m_next = {1'b0, m_reg[19:1]};
                end
                else
                begin
                    r_next     = '0;
                    cnt_next   = CNT_W'(NW);
                    state_next = (state_reg == ST_SPD_MUL) ? ST_SPD_DIV : ST_POS_DIV;
                end
            end

            ST_SPD_DIV, ST_POS_DIV:
            begin
                if (cnt_reg != '0)
                begin
                    a_next   = {a_reg[NW-2:0], qbit};
                    r_next   = qbit ? sum[15:0] : div_t[15:0];
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else if (state_reg == ST_SPD_DIV)
                begin
                    speed_next = (a_reg[NW-1:32] != '0) ? 32'hFFFF_FFFF : a_reg[31:0];
                    state_next = ST_POS_SETUP;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end

            ST_POS_SETUP:
            begin
                b_next     = NW'(ext_mag);
                m_next     = DEG_PER_REV;
                a_next     = '0;
                state_next = ST_POS_MUL;
            end

            ST_OUT:
            begin
                if (!ov_reg || result.ready)
                begin
                    ov_next    = 1'b1;
                    opos_next  = pos_sat;
                    ospd_next  = speed_reg;
                    oraw_next  = 16'(low_reg);
                    owrap_next = wraps_reg;
                    odone_next = done_reg;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cpr_reg    <= CPR_RESET;
            win_reg    <= WIN_RESET;
            pins_reg   <= '0;
            low_reg    <= '0;
            wraps_reg  <= '0;
            wstart_reg <= '0;
            tick_reg   <= '0;
            speed_reg  <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cpr_reg    <= cpr_next;
            win_reg    <= win_next;
            pins_reg   <= pins_next;
            low_reg    <= low_next;
            wraps_reg  <= wraps_next;
            wstart_reg <= wstart_next;
            tick_reg   <= tick_next;
            speed_reg  <= speed_next;
            ov_reg     <= ov_next;
        end
    end

    // datapath and output payload
    always_ff @(posedge clk)
    begin
        done_reg  <= done_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        r_reg     <= r_next;
        m_reg     <= m_next;
        cnt_reg   <= cnt_next;
        opos_reg  <= opos_next;
        ospd_reg  <= ospd_next;
        oraw_reg  <= oraw_next;
        owrap_reg <= owrap_next;
        odone_reg <= odone_next;
    end

    // a transaction taken in makes the core busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> !item.ready)
        else $error("input taken while previous transaction still in work");

    // a new result only appears from the output stage
    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output stage");

    // partial remainder stays below the divisor during the speed and position divides
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SPD_DIV || state_reg == ST_POS_DIV) |-> (r_reg < cpr_eff))
        else $error("divider remainder out of range");

endmodule

### sim/qepv_result_checker.sv
// ----------------------------------------------------------------------------
// qepv_result_checker
// watches the item, result and config ports, predicts every result from its
// own copy of the encoder state and compares it field by field
// ----------------------------------------------------------------------------
module qepv_result_checker
    import qepv_pkg::*;
#(
    parameter int COUNTER_BITS = 16
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_data,
    qepv_in_if          item,
    qepv_out_if         result,
    output int          errors_seen,
    output int          results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] position_deg;
        logic        [31:0] velocity_rpm_q4;
        logic        [15:0] raw_count;
        logic signed [15:0] wrap_count;
        logic               window_done;
    } reading_t;

    reading_t expected_readings[$];

    // register copies
    logic [15:0] cpr;
    logic [9:0]  win;

    // encoder state copies
    logic [1:0]              pins_seen;
    logic [COUNTER_BITS-1:0] low_cnt;
    logic [15:0]             wrap_cnt;
    logic [31:0]             window_origin;
    logic [9:0]              ms_ticks;
    logic [31:0]             held_speed;

    function automatic longint extended_count();
        return longint'($signed(wrap_cnt)) * (longint'(1) << COUNTER_BITS) + longint'(low_cnt);
    endfunction

    // whole degrees, truncated toward zero and clamped to 32-bit signed
    function automatic logic [31:0] degrees_of(longint e);
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] div;
        div = (cpr == 16'd0) ? 64'd1 : {48'd0, cpr};
        mag = (e < 0) ? 64'(-e) : 64'(e);
        q   = mag * 64'd360 / div;
        if (e < 0)
            return (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - q);
        return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    endfunction

    task automatic advance_encoder_state(input logic [1:0] mode, input logic a, input logic b);
        logic [1:0]  pins;
        logic        up;
        logic        down;
        logic        done;
        logic [31:0] now;
        logic [31:0] diff;
        logic [31:0] span;
        logic [63:0] rpm;
        logic [63:0] div;
        int unsigned w;
        reading_t    r;
        pins = {a, b};
        up   = 1'b0;
        down = 1'b0;
        done = 1'b0;
        case (mode)
            MODE_PIN: begin
                case ({pins_seen, pins})
                    {2'd0, 2'd2}, {2'd2, 2'd3}, {2'd3, 2'd1}, {2'd1, 2'd0}: up = 1'b1;
                    {2'd0, 2'd1}, {2'd1, 2'd3}, {2'd3, 2'd2}, {2'd2, 2'd0}: down = 1'b1;
                    default: ;
                endcase
                if (up)
                begin
                    if (&low_cnt)
                        wrap_cnt++;
                    low_cnt++;
                end
                else if (down)
                begin
                    if (low_cnt == '0)
                        wrap_cnt--;
                    low_cnt--;
                end
                pins_seen = pins;
            end
            MODE_CLEAR: low_cnt = '0;
            MODE_TICK: begin
                w = (win == 10'd0) ? 1 : win;
                if (ms_ticks + 1 < w)
                    ms_ticks++;
                else
                begin
                    now  = 32'(extended_count());
                    diff = now - window_origin;
                    span = diff[31] ? 32'd0 - diff : diff;
                    div  = (cpr == 16'd0) ? 64'd1 : {48'd0, cpr};
                    rpm  = {32'd0, span} * 64'd960 * 64'(1000 / w) / div;
                    held_speed    = (rpm > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rpm[31:0];
                    window_origin = now;
                    ms_ticks      = '0;
                    done          = 1'b1;
                end
            end
            default: ;
        endcase
        r.position_deg    = degrees_of(extended_count());
        r.velocity_rpm_q4 = held_speed;
        r.raw_count       = 16'(low_cnt);
        r.wrap_count      = wrap_cnt;
        r.window_done     = done;
        expected_readings.push_back(r);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errors_seen++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track_transactions
        reading_t want;
        if (!rst_n)
        begin
            cpr           = CPR_RESET;
            win           = WIN_RESET;
            pins_seen     = '0;
            low_cnt       = '0;
            wrap_cnt      = '0;
            window_origin = '0;
            ms_ticks      = '0;
            held_speed    = '0;
            expected_readings.delete();
            results_owed <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == CFG_COUNTS_PER_REV)
                    cpr = cfg_data;
                else
                    win = cfg_data[9:0];
            end
            if (result.valid && result.ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    errors_seen++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    compare_field("position_deg", want.position_deg, result.position_deg);
                    compare_field("velocity_rpm_q4", want.velocity_rpm_q4,
                                  result.velocity_rpm_q4);
                    compare_field("raw_count", want.raw_count, result.raw_count);
                    compare_field("wrap_count", want.wrap_count, result.wrap_count);
                    compare_field("window_done", want.window_done, result.window_done);
                end
            end
            if (item.valid && item.ready)
                advance_encoder_state(item.mode, item.chan_a, item.chan_b);
            results_owed <= expected_readings.size();
        end
    end

endmodule

### sim/tb_quadrature_encoder_position_velocity_core.sv
// ----------------------------------------------------------------------------
// tb_quadrature_encoder_position_velocity_core
// stimulus and verdict for the quadrature position/velocity core
// ----------------------------------------------------------------------------
// A short directed sequence walks the decoder through counting in both
// directions, ignored double transitions, the unused item kind, clears, both
// wrap directions and window closes with zero window and zero divisor. Then
// several register settings each get a random phase built mostly from legal
// Gray-code rotations, wrap bursts and tick runs, with noise mixed in. One
// long tick run brings the tick counter to a thousand so that a window
// longer than a thousand closes. The checker beside the core predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tb_quadrature_encoder_position_velocity_core
    import qepv_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         COUNTER_BITS = 16;
    localparam int         LIMIT_CYCLES = 2_000_000;
    localparam int         DRAIN_CYCLES = 250;
    localparam int         HOLD_CYCLES  = 400;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_addr;
    logic [15:0] cfg_data;
    int          errors_seen;
    int          results_owed;
    int          cycle_cnt;

    // stimulus bookkeeping
    int          items_sent;
    logic [1:0]  pins_now;      // pin levels last sent in a pin transaction
    bit          calm;          // no idling on either side
    bit          tx_choppy;
    bit          rx_choppy;
    bit          hold_req;      // asks the receiver for one long hold-off

    qepv_in_if  item_ch ();
    qepv_out_if result_ch ();

    quadrature_encoder_position_velocity_core #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .item     (item_ch),
        .result   (result_ch)
    );

    qepv_result_checker #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .item         (item_ch),
        .result       (result_ch),
        .errors_seen  (errors_seen),
        .results_owed (results_owed)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // gray-code neighbor of p: up follows 0-2-3-1-0, down runs the other way
    function automatic logic [1:0] next_pins(logic [1:0] p, bit up);
        if (up)
        begin
            case (p)
                2'd0:    return 2'd2;
                2'd2:    return 2'd3;
                2'd3:    return 2'd1;
                default: return 2'd0;
            endcase
        end
        case (p)
            2'd0:    return 2'd1;
            2'd1:    return 2'd3;
            2'd3:    return 2'd2;
            default: return 2'd0;
        endcase
    endfunction

    // offer one transaction and return at the edge that takes it
    // valid stays high so a following transaction goes out back to back
    task automatic push_item(input logic [1:0] mode, input logic a, input logic b);
        if (!calm && tx_choppy && $urandom_range(0, 99) < 25)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        if ($urandom_range(0, 39) == 0)
            tx_choppy = !tx_choppy;
        item_ch.valid  <= 1'b1;
        item_ch.mode   <= mode;
        item_ch.chan_a <= a;
        item_ch.chan_b <= b;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // one legal quadrature step
    task automatic step_encoder(input bit up);
        pins_now = next_pins(pins_now, up);
        push_item(MODE_PIN, pins_now[1], pins_now[0]);
    endtask

    task automatic push_tick();
        push_item(MODE_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // clear then step down: each pair takes the wrap count one lower
    task automatic wrap_spin(input int pairs);
        repeat (pairs)
        begin
            push_item(MODE_CLEAR, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            step_encoder(1'b0);
        end
    endtask

    // stop sending, let every result come back, then write both registers
    task automatic set_config(input logic [15:0] cpr, input logic [15:0] win);
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= CFG_COUNTS_PER_REV;
        cfg_data <= cpr;
        @(posedge clk);
        cfg_addr <= CFG_WINDOW_MS;
        cfg_data <= win;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // mostly well-formed encoder traffic with random content, some noise
    task automatic random_phase(input int count, input int tick_pct);
        int  stop;
        int  kind;
        int  len;
        bit  up;
        logic [1:0] m;
        logic a;
        logic b;
        stop = items_sent + count;
        while (items_sent < stop)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 50)
            begin
                // rotation run with ticks mixed in, sometimes reversing
                up  = 1'($urandom_range(0, 1));
                len = $urandom_range(1, 30);
                repeat (len)
                begin
                    if ($urandom_range(0, 99) < tick_pct)
                        push_tick();
                    else
                    begin
                        if ($urandom_range(0, 99) < 5)
                            up = !up;
                        step_encoder(up);
                    end
                end
            end
            else if (kind < 65)
            begin
                // down wraps, sometimes undone by an up wrap
                wrap_spin($urandom_range(1, 12));
                if ($urandom_range(0, 1))
                    step_encoder(1'b1);
            end
            else if (kind < 75)
            begin
                repeat ($urandom_range(1, 8))
                    push_tick();
            end
            else if (kind < 85)
            begin
                case ($urandom_range(0, 3))
                    0: begin
                        // both pins change at once
                        pins_now = pins_now ^ 2'b11;
                        push_item(MODE_PIN, pins_now[1], pins_now[0]);
                    end
                    1: push_item(MODE_PIN, pins_now[1], pins_now[0]);
                    2: push_item(MODE_UNUSED, 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
                    default: push_item(MODE_CLEAR, 1'($urandom_range(0, 1)),
                                       1'($urandom_range(0, 1)));
                endcase
            end
            else
            begin
                // any kind, any pins
                m = 2'($urandom_range(0, 3));
                a = 1'($urandom_range(0, 1));
                b = 1'($urandom_range(0, 1));
                if (m == MODE_PIN)
                    pins_now = {a, b};
                push_item(m, a, b);
            end
        end
    endtask

    // a fixed number of ticks with some motion in between
    task automatic tick_run(input int ticks, input int motion_pct);
        repeat (ticks)
        begin
            if ($urandom_range(0, 99) < motion_pct)
            begin
                if ($urandom_range(0, 9) == 0)
                    push_item(MODE_CLEAR, 1'b0, 1'b1);
                else
                    step_encoder(1'($urandom_range(0, 1)));
            end
            push_tick();
        end
    endtask

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_ch.ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
                result_ch.ready <= 1'b1;
            end
            else if (!calm && rx_choppy && $urandom_range(0, 99) < 20)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
            else
                result_ch.ready <= 1'b1;
            if ($urandom_range(0, 49) == 0)
                rx_choppy = !rx_choppy;
        end
    end

    // run limit
    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("tb_quadrature_encoder_position_velocity_core: errors");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = CFG_COUNTS_PER_REV;
        cfg_data       = '0;
        item_ch.valid  = 1'b0;
        item_ch.mode   = MODE_PIN;
        item_ch.chan_a = 1'b0;
        item_ch.chan_b = 1'b0;
        items_sent     = 0;
        pins_now       = 2'd0;
        calm           = 1'b0;
        tx_choppy      = 1'b1;
        rx_choppy      = 1'b1;
        hold_req       = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at reset register values
        push_item(MODE_PIN, 1'b0, 1'b0);     // same pins, no count
        push_item(MODE_PIN, 1'b1, 1'b0);     // four steps up
        push_item(MODE_PIN, 1'b1, 1'b1);
        push_item(MODE_PIN, 1'b0, 1'b1);
        push_item(MODE_PIN, 1'b0, 1'b0);
        push_item(MODE_PIN, 1'b1, 1'b1);     // both pins change, ignored
        push_item(MODE_PIN, 1'b1, 1'b0);     // one step down
        push_item(MODE_UNUSED, 1'b1, 1'b1);  // unused kind changes nothing
        push_item(MODE_CLEAR, 1'b1, 1'b1);
        push_item(MODE_PIN, 1'b0, 1'b0);     // down wrap below zero
        push_item(MODE_PIN, 1'b1, 1'b0);     // up wrap back to zero
        push_item(MODE_PIN, 1'b0, 1'b0);     // down wrap again
        push_item(MODE_TICK, 1'b1, 1'b1);    // tick, window still open
        pins_now = 2'd0;

        // one-tick window, divisor of one: every tick closes
        set_config(16'd1, 16'd1);
        push_item(MODE_TICK, 1'b0, 1'b0);
        push_item(MODE_PIN, 1'b0, 1'b1);
        push_item(MODE_TICK, 1'b0, 1'b1);
        push_item(MODE_TICK, 1'b0, 1'b0);    // no motion, speed drops to zero

        // zero window and zero divisor both act as one
        set_config(16'd0, 16'd0);
        push_item(MODE_PIN, 1'b1, 1'b1);
        push_item(MODE_TICK, 1'b1, 1'b0);
        push_item(MODE_CLEAR, 1'b0, 1'b0);
        push_item(MODE_TICK, 1'b0, 1'b0);
        pins_now = 2'd3;

        // smallest divisor and window: deep down wraps saturate position
        // and speed
        set_config(16'd1, 16'd1);
        wrap_spin(95);
        random_phase(50, 25);

        // largest divisor; the receiver holds off while items keep coming
        set_config(16'd65535, 16'd3);
        hold_req = 1'b1;
        random_phase(70, 30);

        // zero window again; the closing tick at the end leaves the tick
        // counter at zero for the long run below
        set_config(16'd360, 16'd0);
        random_phase(50, 30);
        push_tick();

        // largest register value: a thousand ticks without a close
        set_config(16'd65535, 16'd1023);
        tick_run(1000, 5);

        // window over a thousand closes on the next tick with zero speed
        set_config(16'd97, 16'd1001);
        push_tick();
        random_phase(30, 20);

        // last part with no idling on either side
        calm = 1'b1;
        set_config(CPR_RESET, 16'd1000);
        random_phase(60, 30);

        // drain
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors_seen == 0)
            $display("tb_quadrature_encoder_position_velocity_core: clean");
        else
            $display("tb_quadrature_encoder_position_velocity_core: errors");
        $finish;
    end

endmodule

### files.f
rtl/core/qepv_pkg.sv
rtl/core/qepv_in_if.sv
rtl/core/qepv_out_if.sv
rtl/core/quadrature_encoder_position_velocity_core.sv
sim/qepv_result_checker.sv
sim/tb_quadrature_encoder_position_velocity_core.sv
